// File: hw/rtl/pipw_pkg.sv
// Package: shared types, constants and CORDIC table for the winding-number core.
`timescale 1ns / 1ps
package pipw_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned CoordBitsDef   = 16;
  localparam int unsigned CountBits      = 5;
  localparam int unsigned AngleBits      = 16;
  localparam int unsigned SumBits        = 21;
  localparam int unsigned CordicSteps    = 14;
  localparam int unsigned StepBits       = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_ROT,
    BK_DONE
  } bk_state_e;

  function automatic logic [AngleBits-1:0] atan_unit(input logic [StepBits-1:0] i);
    logic [AngleBits-1:0] r;
    unique case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pipw_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle, binary angle out.
`timescale 1ns / 1ps
module pipw_cordic #(
  parameter int unsigned W = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [W-1:0]             dx_i,
  input  logic signed [W-1:0]             dy_i,
  output logic                            done_o,
  output logic [pipw_pkg::AngleBits-1:0]  angle_o
);
  import pipw_pkg::*;

  // gain ~1.65 over 14 steps; two extra bits cover growth
  localparam int unsigned XW = W + 2;

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [AngleBits-1:0] z_q, z_d;
  logic [StepBits-1:0]  i_q, i_d;
  logic                 run_q, run_d, done_q, done_d;
  logic signed [XW-1:0] sx, sy;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; run_d = run_q; done_d = 1'b0;
    sx = x_q >>> i_q;
    sy = y_q >>> i_q;
    if (start_i) begin
      if (dx_i < 0) begin
        x_d = -XW'(dx_i); y_d = -XW'(dy_i); z_d = AngleBits'(1) << (AngleBits - 1);
      end else begin
        x_d = XW'(dx_i); y_d = XW'(dy_i); z_d = '0;
      end
      i_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!y_q[XW-1]) begin
        x_d = x_q + sy; y_d = y_q - sx; z_d = z_q + atan_unit(i_q);
      end else begin
        x_d = x_q - sy; y_d = y_q + sx; z_d = z_q - atan_unit(i_q);
      end
      i_d = i_q + StepBits'(1);
      if (i_q == StepBits'(CordicSteps - 1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; i_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

`ifndef SYNTH
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("cordic done while running");
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q && i_q == '0) else $error("cordic start lost");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("cordic done without run");
`endif
endmodule

// File: hw/rtl/pipw_front.sv
// Front end: accepts items and queues loads and queries, in order, for the back end.
`timescale 1ns / 1ps
module pipw_front #(
  parameter int unsigned MAX_VERTICES = pipw_pkg::MaxVerticesDef,
  parameter int unsigned COORD_BITS   = pipw_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [3:0]                    vertex_index_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  output logic                          q_valid_o,
  output logic                          q_op_o,
  output logic [3:0]                    q_index_o,
  output logic [2*COORD_BITS-1:0]       q_point_o,
  input  logic                          q_pop_i
);
  import pipw_pkg::*;

  localparam int unsigned EW = 2 * COORD_BITS + 5;

  // two-entry item queue; loads go through it too so table writes stay in order
  logic [1:0]    cnt_q, cnt_d;
  logic          rd_q, wp_q;
  logic [EW-1:0] mem_q [2];
  logic          push;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  assign q_valid_o = (cnt_q != 2'd0);
  assign {q_op_o, q_index_o, q_point_o} = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {operation_i, vertex_index_i, coord_x_i, coord_y_i};
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("query queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !q_pop_i |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count slip");
`endif
endmodule

// File: hw/rtl/pipw_back.sv
// Back end: writes loads to the table; per query runs CORDIC per vertex, sums the winding.
`timescale 1ns / 1ps
module pipw_back #(
  parameter int unsigned MAX_VERTICES = pipw_pkg::MaxVerticesDef,
  parameter int unsigned COORD_BITS   = pipw_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [pipw_pkg::CountBits-1:0]       count_i,
  input  logic                                 q_valid_i,
  input  logic                                 q_op_i,
  input  logic [3:0]                           q_index_i,
  input  logic [2*COORD_BITS-1:0]              q_point_i,
  output logic                                 q_pop_o,
  output logic                                 res_valid_o,
  output logic                                 inside_res_o,
  output logic signed [pipw_pkg::SumBits-1:0]  winding_sum_o
);
  import pipw_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = AngleBits + NW + 1;

  logic [2*COORD_BITS-1:0] tab_q [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rdata_q;

  bk_state_e st_q, st_d;
  logic [NW-1:0] n_q, n_d, k_q, k_d;
  logic [AW-1:0] addr;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [AngleBits-1:0] first_q, first_d, prev_q, prev_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic cstart, cdone, pop, wr_en;
  logic [AngleBits-1:0] cang, diff;
  logic signed [DW-1:0] dx, dy;
  logic [NW-1:0] ncap;
  logic res_d, res_q, ins_q;
  logic signed [SumBits-1:0] shown_q;
  logic signed [SW-1:0] fsum;

  // loads out of table range are dropped
  assign wr_en = pop && (op_e'(q_op_i) == OP_LOAD) &&
                 (32'(q_index_i) < 32'(MAX_VERTICES));

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) tab_q[AW'(q_index_i)] <= q_point_i;
    rdata_q <= tab_q[addr];
  end

  assign ncap = (32'(count_i) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_i);
  // read the next vertex index so its data is ready in FETCH
  assign addr = AW'(k_d);

  assign dx = DW'($signed(rdata_q[2*COORD_BITS-1:COORD_BITS])) - DW'(px_q);
  assign dy = DW'($signed(rdata_q[COORD_BITS-1:0])) - DW'(py_q);
  assign diff = cang - prev_q;

  pipw_cordic #(.W(DW)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .dx_i(dx), .dy_i(dy),
    .done_o(cdone), .angle_o(cang)
  );

  always_comb begin
    st_d = st_q; n_d = n_q; k_d = k_q; first_d = first_q; prev_d = prev_q;
    sum_d = sum_q; cstart = 1'b0; pop = 1'b0; res_d = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          if (op_e'(q_op_i) == OP_QUERY) begin
            n_d = ncap; k_d = '0; sum_d = '0;
            st_d = (ncap == '0) ? BK_DONE : BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        cstart = 1'b1;
        st_d = BK_ROT;
      end
      BK_ROT: begin
        if (cdone) begin
          if (k_q == '0) first_d = cang;
          else sum_d = sum_q + SW'($signed(diff));
          prev_d = cang;
          if (k_q == n_q - NW'(1)) begin
            // last vertex: its own step plus the closing step back to the first
            sum_d = sum_q + SW'($signed(diff)) + SW'($signed(first_q - cang));
            if (k_q == '0) sum_d = '0;
            st_d = BK_DONE;
          end else begin
            k_d = k_q + NW'(1);
            st_d = BK_FETCH;
          end
        end
      end
      BK_DONE: begin
        res_d = 1'b1;
        st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // final sum is complete in DONE
  assign fsum = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; res_q <= 1'b0;
    end else begin
      st_q <= st_d; res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; k_q <= k_d; first_q <= first_d; prev_q <= prev_d; sum_q <= sum_d;
    if (pop) begin
      px_q <= $signed(q_point_i[2*COORD_BITS-1:COORD_BITS]);
      py_q <= $signed(q_point_i[COORD_BITS-1:0]);
    end
    if (res_d) begin
      ins_q <= (fsum >= SW'(32768)) || (fsum <= -SW'(32768));
      if (fsum > SW'(1048575)) shown_q <= SumBits'(1048575);
      else if (fsum < -SW'(1048576)) shown_q <= SumBits'(-1048576);
      else shown_q <= SumBits'(fsum);
    end
  end

  assign q_pop_o       = pop;
  assign res_valid_o   = res_q;
  assign inside_res_o  = ins_q;
  assign winding_sum_o = shown_q;

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> st_q == BK_IDLE) else $error("pop outside idle");
  a_res_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> $past(st_q) == BK_DONE) else $error("result without done");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_ROT |-> k_q < n_q) else $error("vertex index out of range");
`endif
endmodule

// File: hw/rtl/point_in_polygon_winding_core.sv
// Top level: winding-number point-in-polygon core.
// Use: raise start with an item; a transfer happens at a rising edge where busy
// is low. operation_i = load writes (coord_x_i, coord_y_i) to the vertex slot
// vertex_index_i and gives no result. operation_i = query tests the point
// against the first vertex_count vertices (capped at MAX_VERTICES), cyclically.
// vertex_count must be written through cfg_we_i / cfg_wdata_i only while nothing is
// in flight; the core does not enforce this. Every query gives one result on
// inside_res_o / winding_sum_o, marked by a one-cycle done_o strobe; the receiver
// cannot stall it. All items pass in order through a two-entry queue; busy rises
// only when it is full. The back end writes a load when it dequeues it and handles a
// query of N vertices as a dequeue, then per vertex a fetch, 14 iterative CORDIC
// steps and a done, then a finish; the shared CORDIC sets the rate, and the queue
// can take new items while the back end is still working on a query.
// Reset clears control state and sets vertex_count to 3; vertex table
// contents are undefined until written.
`timescale 1ns / 1ps
module point_in_polygon_winding_core #(
  parameter int unsigned MAX_VERTICES = pipw_pkg::MaxVerticesDef,
  parameter int unsigned COORD_BITS   = pipw_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [3:0]                          vertex_index_i,
  input  logic signed [COORD_BITS-1:0]        coord_x_i,
  input  logic signed [COORD_BITS-1:0]        coord_y_i,
  input  logic                                cfg_we_i,
  input  logic [pipw_pkg::CountBits-1:0]      cfg_wdata_i,
  output logic                                done_o,
  output logic                                inside_res_o,
  output logic signed [pipw_pkg::SumBits-1:0] winding_sum_o
);
  import pipw_pkg::*;

  logic [CountBits-1:0]    count_q;
  logic                    q_valid, q_pop, q_op;
  logic [3:0]              q_index;
  logic [2*COORD_BITS-1:0] q_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= CountBits'(3);
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  pipw_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .operation_i, .vertex_index_i, .coord_x_i, .coord_y_i,
    .q_valid_o(q_valid), .q_op_o(q_op), .q_index_o(q_index),
    .q_point_o(q_point), .q_pop_i(q_pop)
  );

  pipw_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .count_i(count_q),
    .q_valid_i(q_valid), .q_op_i(q_op), .q_index_i(q_index),
    .q_point_i(q_point), .q_pop_o(q_pop),
    .res_valid_o(done_o), .inside_res_o, .winding_sum_o
  );
endmodule
